### rtl/id3v2_text_frame_extractor_unit_defines.svh
// ----------------------------------------------------------------------------
// ID3v2 text frame extractor assertion macros
// Shared property shapes for the concurrent checks of the extractor.
// ----------------------------------------------------------------------------
`ifndef ID3V2_TEXT_FRAME_EXTRACTOR_UNIT_DEFINES_SVH
`define ID3V2_TEXT_FRAME_EXTRACTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define ID3TFE_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define ID3TFE_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error(msg);

`endif

### rtl/id3tfe_pkg.sv
// ----------------------------------------------------------------------------
// ID3v2 text frame extractor package
// Types, codes and constants shared by the extractor RTL.
// ----------------------------------------------------------------------------
package id3tfe_pkg;

   localparam int DEFAULT_POSITION_BITS = 29;

   // result queue geometry
   localparam int RSP_DEPTH    = 4;
   localparam int RSP_PTR_BITS = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_BITS = $clog2(RSP_DEPTH + 1);

   // configuration register indexes
   localparam logic [1:0] CSR_MAJOR_VERSION = 2'd0;
   localparam logic [1:0] CSR_TITLE_ID      = 2'd1;
   localparam logic [1:0] CSR_PERFORMER_ID  = 2'd2;
   localparam logic [1:0] CSR_SIZE_SYNCSAFE = 2'd3;

   // configuration reset values
   localparam logic [7:0]  RST_MAJOR_VERSION = 8'd3;
   localparam logic [31:0] RST_TITLE_ID      = 32'h5449_5432; // TIT2
   localparam logic [31:0] RST_PERFORMER_ID  = 32'h5450_4531; // TPE1
   localparam logic        RST_SIZE_SYNCSAFE = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_TITLE     = 2'd0;
   localparam logic [1:0] KIND_PERFORMER = 2'd1;
   localparam logic [1:0] KIND_PARSED    = 2'd2;
   localparam logic [1:0] KIND_INVALID   = 2'd3;

   // frame targets
   localparam logic [1:0] TARGET_NONE      = 2'd0;
   localparam logic [1:0] TARGET_TITLE     = 2'd1;
   localparam logic [1:0] TARGET_PERFORMER = 2'd2;

   // tag header
   localparam logic [7:0] CHAR_I        = 8'h49;
   localparam logic [7:0] CHAR_D        = 8'h44;
   localparam logic [7:0] CHAR_3        = 8'h33;
   localparam logic [7:0] FLAG_EXTENDED = 8'h40;
   localparam logic [7:0] FLAG_FOOTER   = 8'h10;
   localparam int         HEADER_SIZE   = 10;
   localparam int         FRAME_HDR_LEN = 10;
   localparam int         EXT_SIZE_LEN  = 4;

   typedef enum logic [2:0] {
      PH_HEADER     = 3'd0,
      PH_EXT_SIZE   = 3'd1,
      PH_EXT_SKIP   = 3'd2,
      PH_FRAME_HDR  = 3'd3,
      PH_FRAME_BODY = 3'd4,
      PH_PADDING    = 3'd5,
      PH_FOOTER     = 3'd6,
      PH_DONE       = 3'd7
   } phase_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] content_byte;
      logic [1:0] text_encoding;
      logic       last_of_frame;
      logic       last_result;
   } rsp_type;

   // up to two results caused by one input item
   typedef struct packed {
      rsp_type first;
      rsp_type second;
      logic    pair;
   } entry_type;

   // what one input item produces, from the parser to the result builder
   typedef struct packed {
      logic content_valid;
      logic content_last;
      logic status_valid;
      logic status_invalid;
   } event_type;

endpackage

### rtl/id3v2_text_frame_extractor_unit.sv
// ----------------------------------------------------------------------------
// ID3v2 text frame extractor
// Parses an ID3v2 tag from a byte stream and emits title/performer text.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one stream byte per item; req_tuser high marks stream byte
//   zero and restarts the parser before that byte.
//   rsp_* carries results: title or performer content bytes with their text
//   encoding, then one "tag parsed" or "tag invalid" status. After a status
//   the block drops bytes until the next restart.
//   csr_* writes the accepted major version, the two frame IDs and the frame
//   size format; write only while no item is in flight.
// Timing:
//   One byte is accepted per cycle while req_tready is high. Each byte is
//   parsed in the cycle it is accepted and its results are registered in a
//   4-entry result queue that drives rsp_*. A byte causes zero, one or two
//   results; two results share one entry, which leaves after the second.
// Reset and stall:
//   Reset clears the parser to the header phase, empties the queue and loads
//   the register defaults. When the receiver stalls, results wait in the
//   queue; req_tready drops only once the queue holds four entries.
// ----------------------------------------------------------------------------
`include "id3v2_text_frame_extractor_unit_defines.svh"

module id3v2_text_frame_extractor_unit #(
   parameter int POSITION_BITS = id3tfe_pkg::DEFAULT_POSITION_BITS
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] restart
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] content_byte, [9:8] text_encoding,
                                    // [10] last_of_frame, [15:11] zero
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast,   // last_result
   // configuration
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int P = POSITION_BITS;
   localparam logic [33:0] POS_MAX = (34'd1 << P) - 34'd1;

   // configuration registers
   logic [7:0]  cfg_version_ff;
   logic [31:0] cfg_title_id_ff;
   logic [31:0] cfg_perf_id_ff;
   logic        cfg_syncsafe_ff;

   // parser state
   id3tfe_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic [P-1:0] pos_ff, pos_in, cur_pos;
   logic [P-1:0] frames_end_ff, frames_end_in, cur_frames_end;
   logic [P-1:0] tag_end_ff, tag_end_in, cur_tag_end;
   logic         footer_ff, footer_in, cur_footer;
   logic         ext_ff, ext_in, cur_ext;
   logic [31:0]  fs_ff, fs_in, cur_fs;
   logic [31:0]  fid_ff, fid_in, cur_fid;
   logic [31:0]  br_ff, br_in, cur_br;
   logic [1:0]   target_ff, target_in, cur_target;
   logic [1:0]   enc_ff, enc_in, cur_enc;

   // datapath helpers
   logic [7:0]  in_byte;
   logic        req_fire;
   logic [P:0]  pos_inc;
   logic        at_end;
   logic [31:0] fs_syncsafe;
   logic [31:0] fs_plain;
   logic [32:0] fe_wide;
   logic [33:0] te_wide;
   logic [32:0] ext_end;
   logic [31:0] br_inc;
   logic [31:0] br_dec;
   logic [31:0] fid_next;
   logic [31:0] fs_hdr;
   logic [1:0]  enc_byte;

   id3tfe_pkg::event_type ev;
   id3tfe_pkg::entry_type entry_in;
   logic                  push;

   // result queue
   id3tfe_pkg::entry_type q_ff [id3tfe_pkg::RSP_DEPTH];
   logic [id3tfe_pkg::RSP_PTR_BITS-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [id3tfe_pkg::RSP_CNT_BITS-1:0] count_ff, count_in;
   logic                  sel_ff;
   id3tfe_pkg::entry_type head;
   id3tfe_pkg::rsp_type   cur_rsp;
   logic                  rsp_fire;
   logic                  pop_entry;

   assign in_byte  = req_tdata;
   assign req_fire = req_tvalid && req_tready;

   // ---------------------------------------------------------------------
   // configuration port
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_version_ff  <= id3tfe_pkg::RST_MAJOR_VERSION;
         cfg_title_id_ff <= id3tfe_pkg::RST_TITLE_ID;
         cfg_perf_id_ff  <= id3tfe_pkg::RST_PERFORMER_ID;
         cfg_syncsafe_ff <= id3tfe_pkg::RST_SIZE_SYNCSAFE;
      end else if (csr_we) begin
         case (csr_index)
            id3tfe_pkg::CSR_MAJOR_VERSION: cfg_version_ff  <= csr_wdata[7:0];
            id3tfe_pkg::CSR_TITLE_ID:      cfg_title_id_ff <= csr_wdata;
            id3tfe_pkg::CSR_PERFORMER_ID:  cfg_perf_id_ff  <= csr_wdata;
            id3tfe_pkg::CSR_SIZE_SYNCSAFE: cfg_syncsafe_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // state as seen by this item: restart clears it before the byte
   // ---------------------------------------------------------------------
   always_comb begin
      if (req_tuser) begin
         cur_phase      = id3tfe_pkg::PH_HEADER;
         cur_pos        = '0;
         cur_frames_end = '0;
         cur_tag_end    = '0;
         cur_footer     = 1'b0;
         cur_ext        = 1'b0;
         cur_fs         = '0;
         cur_fid        = '0;
         cur_br         = '0;
         cur_target     = id3tfe_pkg::TARGET_NONE;
         cur_enc        = 2'd0;
      end else begin
         cur_phase      = phase_ff;
         cur_pos        = pos_ff;
         cur_frames_end = frames_end_ff;
         cur_tag_end    = tag_end_ff;
         cur_footer     = footer_ff;
         cur_ext        = ext_ff;
         cur_fs         = fs_ff;
         cur_fid        = fid_ff;
         cur_br         = br_ff;
         cur_target     = target_ff;
         cur_enc        = enc_ff;
      end
   end

   always_comb begin
      pos_inc     = {1'b0, cur_pos} + {{P{1'b0}}, 1'b1};
      at_end      = pos_inc == {1'b0, cur_frames_end};
      fs_syncsafe = {cur_fs[24:0], in_byte[6:0]};
      fs_plain    = {cur_fs[23:0], in_byte};
      fe_wide     = {1'b0, fs_syncsafe} + 33'(id3tfe_pkg::HEADER_SIZE);
      te_wide     = {1'b0, fe_wide} + (cur_footer ? 34'(id3tfe_pkg::HEADER_SIZE) : 34'd0);
      ext_end     = {1'b0, fs_syncsafe} + 33'(id3tfe_pkg::HEADER_SIZE);
      br_inc      = cur_br + 32'd1;
      br_dec      = (cur_br != 32'd0) ? cur_br - 32'd1 : 32'd0;
      fid_next    = (cur_br < 32'd4) ? {cur_fid[23:0], in_byte} : cur_fid;
      if (cur_br >= 32'd4 && cur_br < 32'd8) begin
         fs_hdr = cfg_syncsafe_ff ? fs_syncsafe : fs_plain;
      end else begin
         fs_hdr = cur_fs;
      end
      enc_byte = (in_byte >= 8'd1 && in_byte <= 8'd3) ? in_byte[1:0] : 2'd0;
   end

   // ---------------------------------------------------------------------
   // next state
   // ---------------------------------------------------------------------
   always_comb begin
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      frames_end_in = frames_end_ff;
      tag_end_in    = tag_end_ff;
      footer_in     = footer_ff;
      ext_in        = ext_ff;
      fs_in         = fs_ff;
      fid_in        = fid_ff;
      br_in         = br_ff;
      target_in     = target_ff;
      enc_in        = enc_ff;
      ev            = '0;

      if (req_fire) begin
         phase_in      = cur_phase;
         pos_in        = pos_inc[P-1:0];
         frames_end_in = cur_frames_end;
         tag_end_in    = cur_tag_end;
         footer_in     = cur_footer;
         ext_in        = cur_ext;
         fs_in         = cur_fs;
         fid_in        = cur_fid;
         br_in         = cur_br;
         target_in     = cur_target;
         enc_in        = cur_enc;

         case (cur_phase)
            id3tfe_pkg::PH_HEADER: begin
               if ((cur_pos == P'(0) && in_byte != id3tfe_pkg::CHAR_I) ||
                   (cur_pos == P'(1) && in_byte != id3tfe_pkg::CHAR_D) ||
                   (cur_pos == P'(2) && in_byte != id3tfe_pkg::CHAR_3) ||
                   (cur_pos == P'(3) && in_byte != cfg_version_ff)) begin
                  ev.status_valid   = 1'b1;
                  ev.status_invalid = 1'b1;
                  phase_in          = id3tfe_pkg::PH_DONE;
               end else if (cur_pos == P'(5)) begin
                  ext_in    = (in_byte & id3tfe_pkg::FLAG_EXTENDED) != 8'd0;
                  footer_in = (in_byte & id3tfe_pkg::FLAG_FOOTER) != 8'd0;
               end else if (cur_pos >= P'(6)) begin
                  fs_in = fs_syncsafe;
                  if (cur_pos == P'(9)) begin
                     if (fs_syncsafe == 32'd0 || te_wide > POS_MAX) begin
                        ev.status_valid   = 1'b1;
                        ev.status_invalid = 1'b1;
                        phase_in          = id3tfe_pkg::PH_DONE;
                     end else begin
                        frames_end_in = fe_wide[P-1:0];
                        tag_end_in    = te_wide[P-1:0];
                        fs_in         = '0;
                        br_in         = '0;
                        if (cur_ext) begin
                           phase_in = id3tfe_pkg::PH_EXT_SIZE;
                        end else begin
                           phase_in  = id3tfe_pkg::PH_FRAME_HDR;
                           fid_in    = '0;
                           target_in = id3tfe_pkg::TARGET_NONE;
                        end
                     end
                  end
               end
            end

            id3tfe_pkg::PH_EXT_SIZE: begin
               fs_in = fs_syncsafe;
               br_in = br_inc;
               if (br_inc >= 32'(id3tfe_pkg::EXT_SIZE_LEN)) begin
                  if (fs_syncsafe < 32'd4 || ext_end >= 33'(cur_frames_end)) begin
                     ev.status_valid   = 1'b1;
                     ev.status_invalid = 1'b1;
                     phase_in          = id3tfe_pkg::PH_DONE;
                  end else if (fs_syncsafe == 32'd4) begin
                     phase_in  = id3tfe_pkg::PH_FRAME_HDR;
                     br_in     = '0;
                     fid_in    = '0;
                     fs_in     = '0;
                     target_in = id3tfe_pkg::TARGET_NONE;
                  end else begin
                     br_in    = fs_syncsafe - 32'd4;
                     phase_in = id3tfe_pkg::PH_EXT_SKIP;
                  end
               end else if (at_end) begin
                  ev.status_valid   = 1'b1;
                  ev.status_invalid = 1'b1;
                  phase_in          = id3tfe_pkg::PH_DONE;
               end
            end

            id3tfe_pkg::PH_EXT_SKIP: begin
               br_in = br_dec;
               if (br_dec == 32'd0) begin
                  phase_in  = id3tfe_pkg::PH_FRAME_HDR;
                  fid_in    = '0;
                  fs_in     = '0;
                  target_in = id3tfe_pkg::TARGET_NONE;
               end else if (at_end) begin
                  ev.status_valid   = 1'b1;
                  ev.status_invalid = 1'b1;
                  phase_in          = id3tfe_pkg::PH_DONE;
               end
            end

            id3tfe_pkg::PH_FRAME_HDR: begin
               fid_in = fid_next;
               fs_in  = fs_hdr;
               br_in  = br_inc;
               if (br_inc == 32'd4 && fid_next == 32'd0) begin
                  // zero frame ID: padding up to the end of the frames
                  phase_in = id3tfe_pkg::PH_PADDING;
                  if (at_end) begin
                     if (cur_footer) begin
                        phase_in = id3tfe_pkg::PH_FOOTER;
                     end else begin
                        ev.status_valid = 1'b1;
                        phase_in        = id3tfe_pkg::PH_DONE;
                     end
                  end
               end else if (br_inc >= 32'(id3tfe_pkg::FRAME_HDR_LEN)) begin
                  if (fs_hdr == 32'd0 || at_end) begin
                     ev.status_valid   = 1'b1;
                     ev.status_invalid = 1'b1;
                     phase_in          = id3tfe_pkg::PH_DONE;
                  end else begin
                     // title wins when both IDs match
                     if (fid_next == cfg_title_id_ff) begin
                        target_in = id3tfe_pkg::TARGET_TITLE;
                     end else if (fid_next == cfg_perf_id_ff) begin
                        target_in = id3tfe_pkg::TARGET_PERFORMER;
                     end else begin
                        target_in = id3tfe_pkg::TARGET_NONE;
                     end
                     br_in    = fs_hdr;
                     phase_in = id3tfe_pkg::PH_FRAME_BODY;
                  end
               end else if (at_end) begin
                  if (fid_next == 32'd0 && br_inc < 32'd4) begin
                     if (cur_footer) begin
                        phase_in = id3tfe_pkg::PH_FOOTER;
                     end else begin
                        ev.status_valid = 1'b1;
                        phase_in        = id3tfe_pkg::PH_DONE;
                     end
                  end else begin
                     ev.status_valid   = 1'b1;
                     ev.status_invalid = 1'b1;
                     phase_in          = id3tfe_pkg::PH_DONE;
                  end
               end
            end

            id3tfe_pkg::PH_FRAME_BODY: begin
               if (cur_br == cur_fs) begin
                  enc_in = enc_byte;
               end else if (cur_target != id3tfe_pkg::TARGET_NONE) begin
                  ev.content_valid = 1'b1;
                  ev.content_last  = (br_dec == 32'd0) || at_end;
               end
               br_in = br_dec;
               if (br_dec == 32'd0) begin
                  phase_in  = id3tfe_pkg::PH_FRAME_HDR;
                  br_in     = '0;
                  fid_in    = '0;
                  fs_in     = '0;
                  target_in = id3tfe_pkg::TARGET_NONE;
                  if (at_end) begin
                     if (cur_footer) begin
                        phase_in = id3tfe_pkg::PH_FOOTER;
                     end else begin
                        ev.status_valid = 1'b1;
                        phase_in        = id3tfe_pkg::PH_DONE;
                     end
                  end
               end else if (at_end) begin
                  // body clipped by the end of the frames
                  ev.status_valid   = 1'b1;
                  ev.status_invalid = 1'b1;
                  phase_in          = id3tfe_pkg::PH_DONE;
               end
            end

            id3tfe_pkg::PH_PADDING: begin
               if (at_end) begin
                  if (cur_footer) begin
                     phase_in = id3tfe_pkg::PH_FOOTER;
                  end else begin
                     ev.status_valid = 1'b1;
                     phase_in        = id3tfe_pkg::PH_DONE;
                  end
               end
            end

            id3tfe_pkg::PH_FOOTER: begin
               if (pos_inc == {1'b0, cur_tag_end}) begin
                  ev.status_valid = 1'b1;
                  phase_in        = id3tfe_pkg::PH_DONE;
               end
            end

            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // results of this item
   // ---------------------------------------------------------------------
   always_comb begin
      id3tfe_pkg::rsp_type content;
      id3tfe_pkg::rsp_type status;

      content.kind          = cur_target - 2'd1;
      content.content_byte  = in_byte;
      content.text_encoding = cur_enc;
      content.last_of_frame = ev.content_last;
      content.last_result   = !ev.status_valid;

      status.kind          = ev.status_invalid ? id3tfe_pkg::KIND_INVALID
                                               : id3tfe_pkg::KIND_PARSED;
      status.content_byte  = 8'd0;
      status.text_encoding = 2'd0;
      status.last_of_frame = 1'b0;
      status.last_result   = 1'b1;

      entry_in.first  = ev.content_valid ? content : status;
      entry_in.second = status;
      entry_in.pair   = ev.content_valid && ev.status_valid;
      push            = ev.content_valid || ev.status_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= id3tfe_pkg::PH_HEADER;
         pos_ff        <= '0;
         frames_end_ff <= '0;
         tag_end_ff    <= '0;
         footer_ff     <= 1'b0;
         ext_ff        <= 1'b0;
         fs_ff         <= '0;
         fid_ff        <= '0;
         br_ff         <= '0;
         target_ff     <= id3tfe_pkg::TARGET_NONE;
         enc_ff        <= 2'd0;
      end else begin
         phase_ff      <= phase_in;
         pos_ff        <= pos_in;
         frames_end_ff <= frames_end_in;
         tag_end_ff    <= tag_end_in;
         footer_ff     <= footer_in;
         ext_ff        <= ext_in;
         fs_ff         <= fs_in;
         fid_ff        <= fid_in;
         br_ff         <= br_in;
         target_ff     <= target_in;
         enc_ff        <= enc_in;
      end
   end

   // ---------------------------------------------------------------------
   // result queue: one entry per item with results, one or two results per entry
   // ---------------------------------------------------------------------
   assign req_tready = count_ff != id3tfe_pkg::RSP_CNT_BITS'(id3tfe_pkg::RSP_DEPTH);
   assign head       = q_ff[rd_ptr_ff];
   assign cur_rsp    = sel_ff ? head.second : head.first;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign pop_entry  = rsp_fire && (sel_ff == head.pair);

   always_comb begin
      case ({push, pop_entry})
         2'b10:   count_in = count_ff + id3tfe_pkg::RSP_CNT_BITS'(1);
         2'b01:   count_in = count_ff - id3tfe_pkg::RSP_CNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sel_ff    <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + id3tfe_pkg::RSP_PTR_BITS'(1);
         end
         // advance to the second result, or drop the whole entry
         if (pop_entry) begin
            rd_ptr_ff <= rd_ptr_ff + id3tfe_pkg::RSP_PTR_BITS'(1);
            sel_ff    <= 1'b0;
         end else if (rsp_fire) begin
            sel_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = count_ff != '0;
   assign rsp_tdata  = {5'd0, cur_rsp.last_of_frame, cur_rsp.text_encoding,
                        cur_rsp.content_byte};
   assign rsp_tuser  = cur_rsp.kind;
   assign rsp_tlast  = cur_rsp.last_result;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   `ID3TFE_ASSERT_IMP(a_count_bound, clock, reset, 1'b1,
      count_ff <= id3tfe_pkg::RSP_CNT_BITS'(id3tfe_pkg::RSP_DEPTH),
      "result queue count exceeds depth")
   `ID3TFE_ASSERT_IMP(a_second_has_pair, clock, reset, sel_ff,
      rsp_tvalid && head.pair, "second result selected on a single entry")
   `ID3TFE_ASSERT_NEXT(a_count_up, clock, reset, push && !pop_entry,
      count_ff == $past(count_ff) + id3tfe_pkg::RSP_CNT_BITS'(1),
      "queue count did not follow a push")
   `ID3TFE_ASSERT_NEXT(a_done_holds, clock, reset,
      phase_ff == id3tfe_pkg::PH_DONE && !(req_fire && req_tuser),
      phase_ff == id3tfe_pkg::PH_DONE, "parser left done without restart")

endmodule

### test/id3tfe_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ID3v2 text frame extractor result checker
// Watches the byte, result and register ports of the extractor. Every
// accepted byte runs through a behavioral tag parser. The parser queues the
// title, performer and status results that the byte should cause. Each
// accepted result is compared field by field with the oldest queued one.
// ----------------------------------------------------------------------------
module id3tfe_result_checker #(
   parameter int POSITION_BITS = id3tfe_pkg::DEFAULT_POSITION_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] restart
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [7:0] content_byte, [9:8] text_encoding,
                                    // [10] last_of_frame, [15:11] zero
   input  logic [1:0]  rsp_tuser,   // [1:0] kind
   input  logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output int          mismatches,
   output int          outstanding
);

   localparam logic [31:0] POS_MASK   = 32'((64'd1 << POSITION_BITS) - 1);
   localparam logic [1:0]  ENC_LATIN1 = 2'd0;
   localparam logic [1:0]  ENC_UTF8   = 2'd3;

   // register copies
   logic [7:0]  cfg_version;
   logic [31:0] cfg_title_id;
   logic [31:0] cfg_performer_id;
   logic        cfg_syncsafe;

   // parser state
   id3tfe_pkg::phase_type parse_phase;
   logic [31:0] stream_pos;
   logic [31:0] frames_limit;
   logic [31:0] tag_limit;
   logic        has_footer;
   logic        has_ext_header;
   logic [31:0] size_accum;
   logic [31:0] frame_id;
   logic [31:0] byte_count;
   logic [1:0]  frame_target;
   logic [1:0]  text_enc;

   id3tfe_pkg::rsp_type byte_results[$];
   id3tfe_pkg::rsp_type awaited_results[$];
   int          mismatch_tally;

   function automatic void clear_parser();
      parse_phase    = id3tfe_pkg::PH_HEADER;
      stream_pos     = '0;
      frames_limit   = '0;
      tag_limit      = '0;
      has_footer     = 1'b0;
      has_ext_header = 1'b0;
      size_accum     = '0;
      frame_id       = '0;
      byte_count     = '0;
      frame_target   = id3tfe_pkg::TARGET_NONE;
      text_enc       = ENC_LATIN1;
   endfunction

   function automatic void add_result(logic [1:0] kind, logic [7:0] content,
                                      logic [1:0] enc, logic frame_end);
      id3tfe_pkg::rsp_type r;
      r.kind          = kind;
      r.content_byte  = content;
      r.text_encoding = enc;
      r.last_of_frame = frame_end;
      r.last_result   = 1'b0;
      byte_results    = {byte_results, r};
   endfunction

   function automatic void flag_invalid();
      add_result(id3tfe_pkg::KIND_INVALID, 8'd0, 2'd0, 1'b0);
      parse_phase = id3tfe_pkg::PH_DONE;
   endfunction

   function automatic void close_frames();
      if (has_footer) begin
         parse_phase = id3tfe_pkg::PH_FOOTER;
      end else begin
         add_result(id3tfe_pkg::KIND_PARSED, 8'd0, 2'd0, 1'b0);
         parse_phase = id3tfe_pkg::PH_DONE;
      end
   endfunction

   function automatic void open_frame_header();
      parse_phase  = id3tfe_pkg::PH_FRAME_HDR;
      byte_count   = '0;
      frame_id     = '0;
      size_accum   = '0;
      frame_target = id3tfe_pkg::TARGET_NONE;
   endfunction

   task automatic parse_tag_byte(input logic [7:0] b, input logic restart);
      logic [31:0] p;
      logic        at_end;
      logic [63:0] frames_sum;
      logic [63:0] tag_sum;
      logic [31:0] cnt;
      logic [31:0] rem;
      id3tfe_pkg::rsp_type r;
      byte_results.delete();
      if (restart) clear_parser();
      p      = stream_pos;
      at_end = (64'(p) + 64'd1 == 64'(frames_limit));

      case (parse_phase)
         id3tfe_pkg::PH_HEADER: begin
            if ((p == 0 && b != id3tfe_pkg::CHAR_I) || (p == 1 && b != id3tfe_pkg::CHAR_D) ||
                (p == 2 && b != id3tfe_pkg::CHAR_3) || (p == 3 && b != cfg_version)) begin
               flag_invalid();
            end else if (p == 5) begin
               has_ext_header = (b & id3tfe_pkg::FLAG_EXTENDED) != 0;
               has_footer     = (b & id3tfe_pkg::FLAG_FOOTER) != 0;
            end else if (p >= 6) begin
               size_accum = {size_accum[24:0], b[6:0]};
               if (p == 9) begin
                  frames_sum = 64'(size_accum) + id3tfe_pkg::HEADER_SIZE;
                  // footer is a header-sized trailer
                  tag_sum    = frames_sum + (has_footer ? id3tfe_pkg::HEADER_SIZE : 0);
                  if (size_accum == 0 || tag_sum > 64'(POS_MASK)) begin
                     flag_invalid();
                  end else begin
                     frames_limit = frames_sum[31:0];
                     tag_limit    = tag_sum[31:0];
                     size_accum   = '0;
                     byte_count   = '0;
                     if (has_ext_header) parse_phase = id3tfe_pkg::PH_EXT_SIZE;
                     else open_frame_header();
                  end
               end
            end
         end
         id3tfe_pkg::PH_EXT_SIZE: begin
            size_accum = {size_accum[24:0], b[6:0]};
            byte_count = byte_count + 1;
            if (byte_count >= id3tfe_pkg::EXT_SIZE_LEN) begin
               if (size_accum < id3tfe_pkg::EXT_SIZE_LEN ||
                   64'(size_accum) + id3tfe_pkg::HEADER_SIZE >= 64'(frames_limit)) begin
                  flag_invalid();
               end else if (size_accum == id3tfe_pkg::EXT_SIZE_LEN) begin
                  open_frame_header();
               end else begin
                  byte_count  = size_accum - id3tfe_pkg::EXT_SIZE_LEN;
                  parse_phase = id3tfe_pkg::PH_EXT_SKIP;
               end
            end else if (at_end) begin
               flag_invalid();
            end
         end
         id3tfe_pkg::PH_EXT_SKIP: begin
            if (byte_count > 0) byte_count = byte_count - 1;
            if (byte_count == 0) open_frame_header();
            else if (at_end) flag_invalid();
         end
         id3tfe_pkg::PH_FRAME_HDR: begin
            // four ID bytes, four size bytes, two flag bytes
            cnt = byte_count;
            if (cnt < 4) begin
               frame_id = {frame_id[23:0], b};
            end else if (cnt < 8) begin
               size_accum = cfg_syncsafe ? {size_accum[24:0], b[6:0]}
                                         : {size_accum[23:0], b};
            end
            cnt        = cnt + 1;
            byte_count = cnt;
            if (cnt == 4 && frame_id == 0) begin
               parse_phase = id3tfe_pkg::PH_PADDING;
               if (at_end) close_frames();
            end else if (cnt >= id3tfe_pkg::FRAME_HDR_LEN) begin
               if (size_accum == 0 || at_end) begin
                  flag_invalid();
               end else begin
                  if (frame_id == cfg_title_id) begin
                     frame_target = id3tfe_pkg::TARGET_TITLE;
                  end else if (frame_id == cfg_performer_id) begin
                     frame_target = id3tfe_pkg::TARGET_PERFORMER;
                  end else begin
                     frame_target = id3tfe_pkg::TARGET_NONE;
                  end
                  byte_count  = size_accum;
                  parse_phase = id3tfe_pkg::PH_FRAME_BODY;
               end
            end else if (at_end) begin
               // all-zero header cut off by the end of the frames is padding
               if (frame_id == 0 && cnt < 4) close_frames();
               else flag_invalid();
            end
         end
         id3tfe_pkg::PH_FRAME_BODY: begin
            rem = (byte_count > 0) ? byte_count - 1 : 32'd0;
            if (byte_count == size_accum) begin
               text_enc = (b >= 8'd1 && b <= 8'(ENC_UTF8)) ? b[1:0] : ENC_LATIN1;
            end else if (frame_target != id3tfe_pkg::TARGET_NONE) begin
               add_result((frame_target == id3tfe_pkg::TARGET_TITLE) ?
                             id3tfe_pkg::KIND_TITLE : id3tfe_pkg::KIND_PERFORMER,
                          b, text_enc, rem == 0 || at_end);
            end
            byte_count = rem;
            if (rem == 0) begin
               open_frame_header();
               if (at_end) close_frames();
            end else if (at_end) begin
               flag_invalid();
            end
         end
         id3tfe_pkg::PH_PADDING: begin
            if (at_end) close_frames();
         end
         id3tfe_pkg::PH_FOOTER: begin
            if (64'(p) + 64'd1 == 64'(tag_limit)) begin
               add_result(id3tfe_pkg::KIND_PARSED, 8'd0, 2'd0, 1'b0);
               parse_phase = id3tfe_pkg::PH_DONE;
            end
         end
         default: ;
      endcase

      stream_pos = (p + 1) & POS_MASK;
      foreach (byte_results[i]) begin
         r               = byte_results[i];
         r.last_result   = (i == byte_results.size() - 1);
         awaited_results = {awaited_results, r};
      end
   endtask

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         mismatch_tally++;
      end
   endfunction

   always @(posedge clock) begin
      id3tfe_pkg::rsp_type want;
      if (reset) begin
         cfg_version      = id3tfe_pkg::RST_MAJOR_VERSION;
         cfg_title_id     = id3tfe_pkg::RST_TITLE_ID;
         cfg_performer_id = id3tfe_pkg::RST_PERFORMER_ID;
         cfg_syncsafe     = id3tfe_pkg::RST_SIZE_SYNCSAFE;
         clear_parser();
         awaited_results.delete();
         mismatch_tally = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               id3tfe_pkg::CSR_MAJOR_VERSION: cfg_version      = csr_wdata[7:0];
               id3tfe_pkg::CSR_TITLE_ID:      cfg_title_id     = csr_wdata;
               id3tfe_pkg::CSR_PERFORMER_ID:  cfg_performer_id = csr_wdata;
               id3tfe_pkg::CSR_SIZE_SYNCSAFE: cfg_syncsafe     = csr_wdata[0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (awaited_results.size() == 0) begin
               $display({"%0t: result with none expected, expected nothing, ",
                         "actual kind %0d data 0x%0h last %0b"},
                        $time, rsp_tuser, rsp_tdata, rsp_tlast);
               mismatch_tally++;
            end else begin
               want = awaited_results.pop_front();
               check_field("kind", 8'(want.kind), 8'(rsp_tuser));
               check_field("content_byte", want.content_byte, rsp_tdata[7:0]);
               check_field("text_encoding", 8'(want.text_encoding), 8'(rsp_tdata[9:8]));
               check_field("last_of_frame", 8'(want.last_of_frame), 8'(rsp_tdata[10]));
               check_field("last_result", 8'(want.last_result), 8'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) parse_tag_byte(req_tdata, req_tuser);
      end
      mismatches  <= mismatch_tally;
      outstanding <= awaited_results.size();
   end

endmodule

### test/tb_id3v2_text_frame_extractor_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ID3v2 text frame extractor testbench
// Feeds short directed header faults, then random ID3v2 tags. The tags have
// extended headers, title, performer and other frames, padding, footers,
// wrong sizes and noise. The register settings and the idle patterns on both
// streams change from phase to phase. The result checker scores the output.
// ----------------------------------------------------------------------------
module tb_id3v2_text_frame_extractor_unit;

   localparam int TOTAL_ITEMS   = 1400;
   localparam int PHASE_ITEMS   = 250;
   localparam int SETTLE_CYCLES = 16;
   localparam int TIMEOUT_NS    = 4_000_000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;

   int          mismatches;
   int          outstanding;
   int          items_sent;
   int          idle_pct;
   int          stall_pct;

   logic [7:0]  cur_version;
   logic [31:0] cur_title;
   logic [31:0] cur_performer;
   logic        cur_syncsafe;
   logic [7:0]  tag_body[$];

   id3v2_text_frame_extractor_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   id3tfe_result_checker result_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic send_item(input logic [7:0] data, input logic restart);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= restart;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   // hold the sender until every expected result is out, then let the block settle
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic load_config(input logic [7:0] version, input logic [31:0] title,
                              input logic [31:0] performer, input logic syncsafe);
      write_csr(id3tfe_pkg::CSR_MAJOR_VERSION, 32'(version));
      write_csr(id3tfe_pkg::CSR_TITLE_ID, title);
      write_csr(id3tfe_pkg::CSR_PERFORMER_ID, performer);
      write_csr(id3tfe_pkg::CSR_SIZE_SYNCSAFE, 32'(syncsafe));
      csr_we <= 1'b0;
      @(posedge clock);
      cur_version   = version;
      cur_title     = title;
      cur_performer = performer;
      cur_syncsafe  = syncsafe;
   endtask

   // append a four-byte size, seven bits per byte with a random top bit when syncsafe
   function automatic void put_size(logic [31:0] value, logic syncsafe);
      for (int i = 3; i >= 0; i--) begin
         if (syncsafe) tag_body = {tag_body, {1'($urandom), 7'(value >> (7 * i))}};
         else tag_body = {tag_body, value[8 * i +: 8]};
      end
   endfunction

   task automatic send_tag();
      logic [7:0]  flags;
      logic [7:0]  hdr[10];
      logic [31:0] id;
      logic [31:0] frame_len;
      int          ext_len;
      int          tag_size;
      tag_body.delete();
      flags    = 8'($urandom);
      flags[6] = ($urandom_range(3) == 0);
      flags[4] = ($urandom_range(2) == 0);
      if (flags[6]) begin
         ext_len = ($urandom_range(7) == 0) ? $urandom_range(3) : $urandom_range(4, 10);
         put_size(ext_len, 1'b1);
         if (ext_len > 4) repeat (ext_len - 4) tag_body = {tag_body, 8'($urandom)};
      end
      repeat ($urandom_range(4)) begin
         case ($urandom_range(9))
            0, 1, 2, 3: id = cur_title;
            4, 5, 6:    id = cur_performer;
            7, 8:       id = $urandom;
            default:    id = 32'd0;
         endcase
         case ($urandom_range(11))
            0:       frame_len = 32'd0;
            1:       frame_len = $urandom;   // runs past the tag end
            2:       frame_len = 32'd1;
            default: frame_len = $urandom_range(2, 12);
         endcase
         for (int i = 3; i >= 0; i--) tag_body = {tag_body, id[8 * i +: 8]};
         put_size(frame_len, cur_syncsafe);
         repeat (2) tag_body = {tag_body, 8'($urandom)};
         if (frame_len != 0) begin
            tag_body = {tag_body, ($urandom_range(1) == 0) ? 8'($urandom_range(3))
                                                            : 8'($urandom)};
            for (int k = 1; k < frame_len && k < 24; k++) begin
               tag_body = {tag_body, 8'($urandom)};
            end
         end
      end
      if ($urandom_range(2) == 0) begin
         repeat ($urandom_range(1, 6)) tag_body = {tag_body, 8'd0};
      end

      tag_size = tag_body.size();
      case ($urandom_range(11))
         0: tag_size = tag_size - int'($urandom_range(1, 6));
         1: tag_size = tag_size + int'($urandom_range(1, 6));
         2: tag_size = $urandom_range(1, 3);
         default: ;
      endcase
      if (tag_size < 0) tag_size = 0;

      hdr[0] = id3tfe_pkg::CHAR_I;
      hdr[1] = id3tfe_pkg::CHAR_D;
      hdr[2] = id3tfe_pkg::CHAR_3;
      hdr[3] = ($urandom_range(19) == 0) ? 8'($urandom) : cur_version;
      hdr[4] = 8'($urandom);
      hdr[5] = flags;
      for (int i = 0; i < 4; i++) hdr[6 + i] = {1'($urandom), 7'(tag_size >> (7 * (3 - i)))};
      if ($urandom_range(24) == 0) hdr[$urandom_range(3)] = 8'($urandom);

      for (int i = 0; i < 10; i++) send_item(hdr[i], i == 0);
      foreach (tag_body[i]) send_item(tag_body[i], 1'b0);
      if (flags[4]) repeat (id3tfe_pkg::HEADER_SIZE) send_item(8'($urandom), 1'b0);
      repeat ($urandom_range(3)) send_item(8'($urandom), 1'b0);
   endtask

   task automatic send_noise();
      repeat ($urandom_range(1, 8)) send_item(8'($urandom), 1'($urandom));
   endtask

   initial begin
      #(TIMEOUT_NS);
      $display("tb_id3v2_text_frame_extractor_unit NOT OK");
      $finish;
   end

   initial begin
      int phase_start;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'd0;
      req_tuser     = 1'b0;
      rsp_tready    = 1'b0;
      csr_we        = 1'b0;
      csr_index     = id3tfe_pkg::CSR_MAJOR_VERSION;
      csr_wdata     = 32'd0;
      idle_pct      = 0;
      stall_pct     = 0;
      items_sent    = 0;
      cur_version   = id3tfe_pkg::RST_MAJOR_VERSION;
      cur_title     = id3tfe_pkg::RST_TITLE_ID;
      cur_performer = id3tfe_pkg::RST_PERFORMER_ID;
      cur_syncsafe  = id3tfe_pkg::RST_SIZE_SYNCSAFE;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // bad first byte, both extremes
      send_item(8'hFF, 1'b1);
      send_item(8'h00, 1'b1);
      // bad third byte
      send_item(id3tfe_pkg::CHAR_I, 1'b1);
      send_item(id3tfe_pkg::CHAR_D, 1'b0);
      send_item(8'h00, 1'b0);
      // wrong major version
      send_item(id3tfe_pkg::CHAR_I, 1'b1);
      send_item(id3tfe_pkg::CHAR_D, 1'b0);
      send_item(id3tfe_pkg::CHAR_3, 1'b0);
      send_item(8'hFF, 1'b0);
      // zero tag size, then bytes past the verdict that must be dropped
      send_item(id3tfe_pkg::CHAR_I, 1'b1);
      send_item(id3tfe_pkg::CHAR_D, 1'b0);
      send_item(id3tfe_pkg::CHAR_3, 1'b0);
      send_item(id3tfe_pkg::RST_MAJOR_VERSION, 1'b0);
      repeat (6) send_item(8'h00, 1'b0);
      send_item(8'h80, 1'b0);
      send_item(8'h7F, 1'b0);
      settle();

      for (int ph = 0; items_sent < TOTAL_ITEMS; ph++) begin
         case (ph)
            0: load_config(id3tfe_pkg::RST_MAJOR_VERSION, id3tfe_pkg::RST_TITLE_ID,
                           id3tfe_pkg::RST_PERFORMER_ID, id3tfe_pkg::RST_SIZE_SYNCSAFE);
            1: load_config(8'd4, id3tfe_pkg::RST_TITLE_ID, id3tfe_pkg::RST_TITLE_ID, 1'b0);
            2: load_config(8'd0, 32'hFFFF_FFFF, 32'd0, 1'b1);
            3: load_config(8'hFF, $urandom, $urandom, 1'b0);
            default: load_config(8'($urandom), $urandom, $urandom, 1'($urandom));
         endcase
         case (ph % 4)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 45;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 45;
            end
            default: begin
               idle_pct  = 31;
               stall_pct = 31;
            end
         endcase
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS && items_sent < TOTAL_ITEMS) begin
            if ($urandom_range(14) == 0) send_noise();
            else send_tag();
            if (ph == 2) settle();
         end
         settle();
      end

      if (mismatches == 0) begin
         $display("tb_id3v2_text_frame_extractor_unit OK");
      end else begin
         $display("tb_id3v2_text_frame_extractor_unit NOT OK");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/id3tfe_pkg.sv
rtl/id3v2_text_frame_extractor_unit.sv
test/id3tfe_result_checker.sv
test/tb_id3v2_text_frame_extractor_unit.sv
